FILE: hdl/i2c_master_bit_engine_assert.svh
// Assertion macros for the I2C master bit engine.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising clock edge outside of reset.
`define I2CMBE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("i2cmbe: assertion failed");
// Checked on every rising clock edge, reset included.
`define I2CMBE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("i2cmbe: assertion failed");
`else
`define I2CMBE_ASSERT(lbl, prop)
`define I2CMBE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: hdl/i2cmbe_pkg.sv
// Types and constants shared by the I2C master bit engine.
`timescale 1ns / 1ps
package i2cmbe_pkg;

  // Line phases of the bit engine.
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_S1     = 4'd1,
    PH_S2     = 4'd2,
    PH_S3     = 4'd3,
    PH_S4     = 4'd4,
    PH_P1     = 4'd5,
    PH_P2     = 4'd6,
    PH_P3     = 4'd7,
    PH_WDATA  = 4'd8,
    PH_WHIGH  = 4'd9,
    PH_WLOW   = 4'd10,
    PH_WACK   = 4'd11,
    PH_RWAIT  = 4'd12,
    PH_RHIGH1 = 4'd13,
    PH_RHIGH2 = 4'd14,
    PH_RLOW   = 4'd15
  } phase_e;

  // Command codes.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_PHASE_TICKS     = 1'b0,
    CFG_STRETCH_TIMEOUT = 1'b1
  } cfg_e;

  localparam logic [3:0] BYTE_BITS         = 4'd8;
  localparam logic [3:0] ACK_BIT           = 4'd9;
  localparam logic [7:0] PHASE_TICKS_RST   = 8'd1;
  localparam logic [7:0] STRETCH_TOUT_RST  = 8'd255;

  // One tick of sampled lines and an optional command.
  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] operation;
    logic [7:0] tx_byte;
    logic       ack_to_send;
    logic       scl_in;
    logic       sda_in;
  } in_item_t;

  // Line drive and status after one tick.
  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
    logic       timeout_error;
  } out_item_t;

endpackage

FILE: hdl/i2c_master_bit_engine.sv
// I2C master bit engine: one line tick per transaction, registered result.
`timescale 1ns / 1ps
`include "i2c_master_bit_engine_assert.svh"

// Each input transaction is one tick of the open-drain I2C line machine:
// sampled SCL/SDA plus an optional start, stop, write-byte or read-byte
// command, taken only when the engine reports not busy. The tick is
// processed combinationally between the state registers and the result
// register, so one transaction is accepted every clock cycle; the input
// stalls only while the result register is full and the output is stalled.
// Every line phase lasts phase_ticks ticks (0 acts as 1). Read bytes wait
// for SCL high and abort with timeout_error once the per-byte stretch count
// reaches stretch_timeout. Configuration writes belong to idle periods.
module i2c_master_bit_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  i2cmbe_pkg::in_item_t in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output i2cmbe_pkg::out_item_t out_data_o
);
  import i2cmbe_pkg::*;

  // Configuration registers.
  logic [7:0] phase_ticks_q;
  logic [7:0] stretch_tout_q;

  // Engine state.
  phase_e     phase_q, phase_d;
  logic [3:0] bit_cnt_q, bit_cnt_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] stretch_q, stretch_d;
  logic [7:0] delay_q, delay_d;
  op_e        op_q, op_d;
  logic       ack_hold_q, ack_hold_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic [7:0] rx_q, rx_d;
  logic       ack_flag_q, ack_flag_d;
  logic       err_q, err_d;
  logic       done_d;

  // Result register.
  logic       out_valid_q;
  out_item_t  out_data_q;
  out_item_t  res_d;

  logic       in_acc;
  logic [7:0] delay_load;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A phase of zero ticks behaves as one tick.
  assign delay_load = (phase_ticks_q == 8'd0) ? 8'd0 : (phase_ticks_q - 8'd1);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q  <= PHASE_TICKS_RST;
      stretch_tout_q <= STRETCH_TOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_PHASE_TICKS:     phase_ticks_q  <= cfg_data_i;
        CFG_STRETCH_TIMEOUT: stretch_tout_q <= cfg_data_i;
        default:             phase_ticks_q  <= phase_ticks_q;
      endcase
    end
  end

  // Next state of one tick: pick the phase transition, then apply the
  // entry actions of the phase being entered.
  always_comb begin
    phase_e next_ph;
    logic   enter;
    next_ph    = PH_IDLE;
    enter      = 1'b0;
    phase_d    = phase_q;
    bit_cnt_d  = bit_cnt_q;
    shift_d    = shift_q;
    stretch_d  = stretch_q;
    delay_d    = delay_q;
    op_d       = op_q;
    ack_hold_d = ack_hold_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    rx_d       = rx_q;
    ack_flag_d = ack_flag_q;
    err_d      = err_q;
    done_d     = 1'b0;

    if (phase_q == PH_IDLE) begin
      if (in_data_i.cmd_valid) begin
        op_d      = op_e'(in_data_i.operation);
        bit_cnt_d = 4'd0;
        enter     = 1'b1;
        unique case (op_e'(in_data_i.operation))
          OP_START: next_ph = PH_S1;
          OP_STOP:  next_ph = PH_P1;
          OP_WRITE: begin
            shift_d = in_data_i.tx_byte;
            next_ph = PH_WDATA;
          end
          OP_READ: begin
            ack_hold_d = in_data_i.ack_to_send;
            shift_d    = 8'd0;
            stretch_d  = 8'd0;
            err_d      = 1'b0;
            next_ph    = PH_RWAIT;
          end
          default: next_ph = PH_IDLE;
        endcase
      end
    end else if (phase_q == PH_RWAIT) begin
      // Wait for SCL high; stretch ticks count toward the timeout.
      if (in_data_i.scl_in) begin
        enter   = 1'b1;
        next_ph = PH_RHIGH1;
      end else if (stretch_q >= stretch_tout_q) begin
        scl_d   = 1'b1;
        sda_d   = 1'b1;
        err_d   = 1'b1;
        phase_d = PH_IDLE;
        done_d  = 1'b1;
      end else begin
        stretch_d = stretch_q + 8'd1;
      end
    end else if (delay_q != 8'd0) begin
      delay_d = delay_q - 8'd1;
    end else begin
      unique case (phase_q)
        PH_S1: begin enter = 1'b1; next_ph = PH_S2; end
        PH_S2: begin enter = 1'b1; next_ph = PH_S3; end
        PH_S3: begin enter = 1'b1; next_ph = PH_S4; end
        PH_P1: begin enter = 1'b1; next_ph = PH_P2; end
        PH_P2: begin enter = 1'b1; next_ph = PH_P3; end
        PH_WDATA: begin enter = 1'b1; next_ph = PH_WHIGH; end
        PH_WHIGH: begin enter = 1'b1; next_ph = PH_WLOW; end
        PH_WLOW: begin
          enter   = 1'b1;
          next_ph = (bit_cnt_q < BYTE_BITS) ? PH_WDATA : PH_WACK;
        end
        PH_WACK: begin
          ack_flag_d = ~in_data_i.sda_in;
          scl_d      = 1'b0;
          phase_d    = PH_IDLE;
          done_d     = 1'b1;
        end
        PH_RHIGH1: begin
          shift_d   = {shift_q[6:0], in_data_i.sda_in};
          bit_cnt_d = bit_cnt_q + 4'd1;
          enter     = 1'b1;
          next_ph   = PH_RHIGH2;
        end
        PH_RHIGH2: begin
          if (bit_cnt_q > BYTE_BITS) begin
            scl_d   = 1'b0;
            sda_d   = 1'b1;
            rx_d    = shift_q;
            phase_d = PH_IDLE;
            done_d  = 1'b1;
          end else begin
            enter   = 1'b1;
            next_ph = PH_RLOW;
          end
        end
        PH_RLOW: begin
          enter = 1'b1;
          if (bit_cnt_q < BYTE_BITS) begin
            next_ph = PH_RWAIT;
          end else begin
            bit_cnt_d = ACK_BIT;
            next_ph   = PH_RHIGH2;
          end
        end
        default: begin
          // End of a start or stop condition.
          phase_d = PH_IDLE;
          done_d  = 1'b1;
        end
      endcase
    end

    // Entry actions of the new phase.
    if (enter) begin
      phase_d = next_ph;
      delay_d = delay_load;
      unique case (next_ph)
        PH_S1:     sda_d = 1'b1;
        PH_S2:     scl_d = 1'b1;
        PH_S3:     sda_d = 1'b0;
        PH_S4:     scl_d = 1'b0;
        PH_P1:     sda_d = 1'b0;
        PH_P2:     scl_d = 1'b1;
        PH_P3:     sda_d = 1'b1;
        PH_WDATA: begin
          sda_d   = shift_d[7];
          shift_d = {shift_d[6:0], 1'b0};
        end
        PH_WHIGH:  scl_d = 1'b1;
        PH_WLOW: begin
          scl_d     = 1'b0;
          bit_cnt_d = bit_cnt_d + 4'd1;
        end
        PH_WACK, PH_RWAIT: begin
          sda_d = 1'b1;
          scl_d = 1'b1;
        end
        PH_RHIGH2: scl_d = 1'b1;
        PH_RLOW: begin
          scl_d = 1'b0;
          if (bit_cnt_d == BYTE_BITS) sda_d = ~ack_hold_d;
        end
        default: scl_d = scl_d;
      endcase
    end
  end

  // Result of the tick, taken from the next-state values.
  always_comb begin
    res_d.scl_release   = scl_d;
    res_d.sda_release   = sda_d;
    res_d.busy_res      = (phase_d != PH_IDLE);
    res_d.done_res      = done_d;
    res_d.rx_byte       = rx_d;
    res_d.ack_received  = ack_flag_d;
    res_d.timeout_error = err_d;
  end

  // State registers advance once per accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bit_cnt_q  <= 4'd0;
      shift_q    <= 8'd0;
      stretch_q  <= 8'd0;
      delay_q    <= 8'd0;
      op_q       <= OP_START;
      ack_hold_q <= 1'b0;
      scl_q      <= 1'b1;
      sda_q      <= 1'b1;
      rx_q       <= 8'd0;
      ack_flag_q <= 1'b0;
      err_q      <= 1'b0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      bit_cnt_q  <= bit_cnt_d;
      shift_q    <= shift_d;
      stretch_q  <= stretch_d;
      delay_q    <= delay_d;
      op_q       <= op_d;
      ack_hold_q <= ack_hold_d;
      scl_q      <= scl_d;
      sda_q      <= sda_d;
      rx_q       <= rx_d;
      ack_flag_q <= ack_flag_d;
      err_q      <= err_d;
    end
  end

  // Result register: loaded on accept, emptied when the output takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= res_d;
    end
  end

  // Assertions.
  `I2CMBE_ASSERT(a_acc_gives_result, in_acc |=> out_valid_o)
  `I2CMBE_ASSERT(a_done_not_busy, out_valid_q |-> !(out_data_q.done_res && out_data_q.busy_res))
  `I2CMBE_ASSERT(a_rwait_released, (phase_q == PH_RWAIT) |-> (scl_q && sda_q))
  `I2CMBE_ASSERT(a_bit_cnt_range, bit_cnt_q <= ACK_BIT)

endmodule
